FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// trigger implies condition in the next cycle
`define ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/rme_pkg.sv
// shared types, constants and tables of the euler angle block
`timescale 1ns / 1ps
package rme_pkg;

    localparam int IN_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CORDIC_ITERS     = 16;
    localparam int ITER_W           = $clog2(CORDIC_ITERS);
    localparam int PRE_SHIFT        = 8;
    localparam int ZW               = 27;

    localparam logic signed [ZW-1:0] DEG180  = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] OUT_MAX = ZW'(23040);
    localparam logic signed [ZW-1:0] YAW_MAX = ZW'(11520);
    localparam logic [14:0] THR_RESET        = 15'd16352;

    typedef enum logic [1:0] {
        MODE_NORM,
        MODE_LOCK_NEG,
        MODE_LOCK_POS
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [16:0] py;
        logic signed [16:0] px;
        logic signed [16:0] ry;
        logic signed [16:0] rx;
        logic signed [16:0] s;
    } task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [ITER_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = ZW'(2949120);
            4'd1:    v = ZW'(1740967);
            4'd2:    v = ZW'(919879);
            4'd3:    v = ZW'(466945);
            4'd4:    v = ZW'(234379);
            4'd5:    v = ZW'(117304);
            4'd6:    v = ZW'(58666);
            4'd7:    v = ZW'(29335);
            4'd8:    v = ZW'(14668);
            4'd9:    v = ZW'(7334);
            4'd10:   v = ZW'(3667);
            4'd11:   v = ZW'(1833);
            4'd12:   v = ZW'(917);
            4'd13:   v = ZW'(458);
            4'd14:   v = ZW'(229);
            default: v = ZW'(115);
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/rotation_matrix_to_euler.sv
// steps: a queue pop, a setup step, (IN_FRAC_BITS + 1) root steps, a cordic setup step, 16 cordic
// steps and a finish step; gimbal-lock items skip the root steps
// the serial root and cordic take one item at a time; finish waits until a held result is popped
// a two-entry queue takes new items while the back end works and a result waits to be popped
// reset: asynchronous active low, clears queue, control and result valid, threshold to 16352
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gimbal_threshold_we,
    input  logic        [14:0] gimbal_threshold,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] r00,
    input  logic signed [15:0] r01,
    input  logic signed [15:0] r02,
    input  logic signed [15:0] r10,
    input  logic signed [15:0] r11,
    input  logic signed [15:0] r12,
    input  logic signed [15:0] r22,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] pitch_deg,
    output logic signed [14:0] yaw_deg,
    output logic signed [15:0] roll_deg
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    task_t   q_wr_data;
    task_t   q_rd_data;

    rme_front #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .gimbal_threshold_we (gimbal_threshold_we),
        .gimbal_threshold    (gimbal_threshold),
        .push                (push),
        .full                (full),
        .r00                 (r00),
        .r01                 (r01),
        .r02                 (r02),
        .r10                 (r10),
        .r11                 (r11),
        .r12                 (r12),
        .r22                 (r22),
        .q_stat              (q_stat),
        .q_push              (q_push),
        .q_data              (q_wr_data)
    );

    rme_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    rme_back #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .pitch_deg (pitch_deg),
        .yaw_deg   (yaw_deg),
        .roll_deg  (roll_deg)
    );

    `ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty))
    `ASSERT_ALWAYS(a_pop_nonempty, !q_pop || !q_stat.empty)
    `ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_stat.empty)

endmodule

FILE: rtl/core/rme_queue.sv
// small register queue of classified items between front and back
`timescale 1ns / 1ps
module rme_queue
    import rme_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  task_t   wr_data,
    input  logic    rd_en,
    output task_t   rd_data,
    output q_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    task_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/rme_front.sv
// input side: threshold register, gimbal classification and operand setup
`timescale 1ns / 1ps
module rme_front
    import rme_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gimbal_threshold_we,
    input  logic        [14:0] gimbal_threshold,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] r00,
    input  logic signed [15:0] r01,
    input  logic signed [15:0] r02,
    input  logic signed [15:0] r10,
    input  logic signed [15:0] r11,
    input  logic signed [15:0] r12,
    input  logic signed [15:0] r22,
    input  q_stat_t            q_stat,
    output logic               q_push,
    output task_t              q_data
);

    localparam logic signed [32:0] ONE = 33'sd1 <<< IN_FRAC_BITS;

    logic        [14:0] thr_reg;
    logic signed [16:0] thr_s;
    logic signed [16:0] r02_s;
    logic signed [32:0] s_wide;
    logic signed [32:0] s_sat;

    assign full   = q_stat.full;
    assign q_push = push && !q_stat.full;
    assign thr_s  = {2'b00, thr_reg};
    assign r02_s  = {r02[15], r02};
    assign s_wide = {{17{r02[15]}}, r02};

    always_comb
    begin
        if (s_wide > ONE)
        begin
            s_sat = ONE;
        end
        else if (s_wide < -ONE)
        begin
            s_sat = -ONE;
        end
        else
        begin
            s_sat = s_wide;
        end
    end

    always_comb
    begin
        q_data.ry = -{r01[15], r01};
        q_data.rx = {r00[15], r00};
        q_data.s  = s_sat[16:0];
        if (r02_s < -thr_s)
        begin
            q_data.mode = MODE_LOCK_NEG;
            q_data.py   = {r10[15], r10};
            q_data.px   = {r11[15], r11};
        end
        else if (r02_s > thr_s)
        begin
            q_data.mode = MODE_LOCK_POS;
            q_data.py   = {r10[15], r10};
            q_data.px   = {r11[15], r11};
        end
        else
        begin
            q_data.mode = MODE_NORM;
            q_data.py   = -{r12[15], r12};
            q_data.px   = {r22[15], r22};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (gimbal_threshold_we)
        begin
            thr_reg <= gimbal_threshold;
        end
    end

endmodule

FILE: rtl/core/rme_back.sv
// execution side: square root for asin, three cordic lanes, result register
`timescale 1ns / 1ps
module rme_back
    import rme_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  task_t              q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] pitch_deg,
    output logic signed [14:0] yaw_deg,
    output logic signed [15:0] roll_deg
);

    localparam int F  = IN_FRAC_BITS;
    localparam int SW = 2 * F + 1;
    localparam int MW = (SW > 34) ? SW : 34;
    localparam int KW = $clog2(F + 1);
    localparam int XW = ((F + 2 > 17) ? F + 2 : 17) + PRE_SHIFT + 2;
    localparam int NL = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_SQRT,
        ST_INIT,
        ST_ROT,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    task_t                task_reg, task_next;
    logic [SW-1:0]        v_reg, v_next;
    logic [SW-1:0]        res_reg, res_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [ITER_W-1:0]    it_reg, it_next;
    logic signed [XW-1:0] x_reg [NL];
    logic signed [XW-1:0] x_next [NL];
    logic signed [XW-1:0] y_reg [NL];
    logic signed [XW-1:0] y_next [NL];
    logic signed [ZW-1:0] z_reg [NL];
    logic signed [ZW-1:0] z_next [NL];
    logic [NL-1:0]        zero_reg, zero_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [15:0]   pitch_reg, pitch_next;
    logic signed [14:0]   yaw_reg, yaw_next;
    logic signed [15:0]   roll_reg, roll_next;

    logic signed [33:0]   sq;
    logic [MW-1:0]        rem_wide;
    logic [SW-1:0]        bitv;
    logic [SW-1:0]        trial;
    logic signed [XW-1:0] in_x [NL];
    logic signed [XW-1:0] in_y [NL];
    logic signed [15:0]   ang [NL];

    function automatic logic signed [15:0] to_deg(input logic signed [ZW-1:0] z,
                                                  input logic zero);
        logic signed [ZW-1:0] a;
        a = (z + ZW'(256)) >>> 9;
        if (zero)
        begin
            a = '0;
        end
        else if (a > OUT_MAX)
        begin
            a = OUT_MAX;
        end
        else if (a < -OUT_MAX)
        begin
            a = -OUT_MAX;
        end
        return a[15:0];
    endfunction

    assign sq       = task_reg.s * task_reg.s;
    assign rem_wide = (MW'(1) << (2 * F)) - MW'(sq);
    assign bitv     = SW'(1) << {k_reg, 1'b0};
    assign trial    = res_reg + bitv;
    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign empty    = !out_valid_reg;
    assign pitch_deg = pitch_reg;
    assign yaw_deg   = yaw_reg;
    assign roll_deg  = roll_reg;

    always_comb
    begin
        in_y[0] = {{(XW-17){task_reg.py[16]}}, task_reg.py};
        in_x[0] = {{(XW-17){task_reg.px[16]}}, task_reg.px};
        in_y[1] = {{(XW-17){task_reg.s[16]}}, task_reg.s};
        in_x[1] = {{(XW-F-1){1'b0}}, res_reg[F:0]};
        in_y[2] = {{(XW-17){task_reg.ry[16]}}, task_reg.ry};
        in_x[2] = {{(XW-17){task_reg.rx[16]}}, task_reg.rx};
        for (int l = 0; l < NL; l++)
        begin
            ang[l] = to_deg(z_reg[l], zero_reg[l]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        task_next      = task_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        k_next         = k_reg;
        it_next        = it_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !pop;
        pitch_next     = pitch_reg;
        yaw_next       = yaw_reg;
        roll_next      = roll_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    task_next  = q_data;
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                v_next     = rem_wide[SW-1:0];
                res_next   = '0;
                k_next     = KW'(F);
                state_next = (task_reg.mode == MODE_NORM) ? ST_SQRT : ST_INIT;
            end
            ST_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                for (int l = 0; l < NL; l++)
                begin
                    zero_next[l] = (in_x[l] == '0) && (in_y[l] == '0);
                    if (in_x[l] < 0)
                    begin
                        x_next[l] = -(in_x[l] <<< PRE_SHIFT);
                        y_next[l] = -(in_y[l] <<< PRE_SHIFT);
                        z_next[l] = (in_y[l] >= 0) ? DEG180 : -DEG180;
                    end
                    else
                    begin
                        x_next[l] = in_x[l] <<< PRE_SHIFT;
                        y_next[l] = in_y[l] <<< PRE_SHIFT;
                        z_next[l] = '0;
                    end
                end
                it_next    = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                for (int l = 0; l < NL; l++)
                begin
                    if (y_reg[l] >= 0)
                    begin
                        x_next[l] = x_reg[l] + (y_reg[l] >>> it_reg);
                        y_next[l] = y_reg[l] - (x_reg[l] >>> it_reg);
                        z_next[l] = z_reg[l] + atan_tab(it_reg);
                    end
                    else
                    begin
                        x_next[l] = x_reg[l] - (y_reg[l] >>> it_reg);
                        y_next[l] = y_reg[l] + (x_reg[l] >>> it_reg);
                        z_next[l] = z_reg[l] - atan_tab(it_reg);
                    end
                end
                it_next = it_reg + 1'b1;
                if (it_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (task_reg.mode)
                        MODE_LOCK_NEG:
                        begin
                            pitch_next = -ang[0];
                            yaw_next   = -YAW_MAX[14:0];
                            roll_next  = '0;
                        end
                        MODE_LOCK_POS:
                        begin
                            pitch_next = ang[0];
                            yaw_next   = YAW_MAX[14:0];
                            roll_next  = '0;
                        end
                        default:
                        begin
                            pitch_next = ang[0];
                            if (ang[1] > 16'(YAW_MAX))
                            begin
                                yaw_next = YAW_MAX[14:0];
                            end
                            else if (ang[1] < -16'(YAW_MAX))
                            begin
                                yaw_next = -YAW_MAX[14:0];
                            end
                            else
                            begin
                                yaw_next = ang[1][14:0];
                            end
                            roll_next = ang[2];
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        k_reg     <= k_next;
        it_reg    <= it_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        pitch_reg <= pitch_next;
        yaw_reg   <= yaw_next;
        roll_reg  <= roll_next;
    end

endmodule

FILE: bench/tb_rotation_matrix_to_euler.sv
// testbench of the rotation matrix to euler angle block, random and directed items with a predictor
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler;
    import rme_pkg::*;

    localparam int FRAC = 14;
    localparam longint ITEM_DEG180 = 180 * 65536;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [14:0] yaw;
        logic signed [15:0] roll;
    } angles_t;

    logic clk;
    logic rst_n;
    logic gimbal_threshold_we;
    logic [14:0] gimbal_threshold;
    logic push;
    logic full;
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r22;
    logic empty;
    logic pop;
    logic signed [15:0] pitch_deg;
    logic signed [14:0] yaw_deg;
    logic signed [15:0] roll_deg;

    angles_t expected_angles[$];
    int errors;
    int cycles;
    int pop_wait;
    bit idle_off;
    longint thr_model;
    longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                             14668, 7334, 3667, 1833, 917, 458, 229, 115};

    rotation_matrix_to_euler i_dut (
        .clk(clk), .rst_n(rst_n),
        .gimbal_threshold_we(gimbal_threshold_we), .gimbal_threshold(gimbal_threshold),
        .push(push), .full(full),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12), .r22(r22),
        .empty(empty), .pop(pop),
        .pitch_deg(pitch_deg), .yaw_deg(yaw_deg), .roll_deg(roll_deg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint limit(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z, nx, ny;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            z = (y >= 0) ? ITEM_DEG180 : -ITEM_DEG180;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += atan_deg[i];
            end
            else
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= atan_deg[i];
            end
            x = nx;
            y = ny;
        end
        return limit(floor_shift(z + 256, 9), 23040);
    endfunction

    function automatic longint root_of(longint v);
        longint res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic angles_t predict_angles(longint a00, longint a01, longint a02,
                                               longint a10, longint a11, longint a12,
                                               longint a22);
        angles_t o;
        longint one, s;
        one = 64'd1 << FRAC;
        if (a02 < -thr_model)
        begin
            o.pitch = 16'(-angle_of(a10, a11));
            o.yaw = -15'sd11520;
            o.roll = '0;
        end
        else if (a02 > thr_model)
        begin
            o.pitch = 16'(angle_of(a10, a11));
            o.yaw = 15'sd11520;
            o.roll = '0;
        end
        else
        begin
            s = limit(a02, one);
            o.pitch = 16'(angle_of(-a12, a22));
            o.yaw = 15'(limit(angle_of(s, root_of(one * one - s * s)), 11520));
            o.roll = 16'(angle_of(-a01, a00));
        end
        return o;
    endfunction

    task automatic send_matrix(int a00, int a01, int a02, int a10, int a11, int a12, int a22);
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        r00 <= 16'(a00); r01 <= 16'(a01); r02 <= 16'(a02);
        r10 <= 16'(a10); r11 <= 16'(a11); r12 <= 16'(a12); r22 <= 16'(a22);
        push <= 1'b1;
        expected_angles.insert(expected_angles.size(),
                               predict_angles(a00, a01, a02, a10, a11, a12, a22));
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_angles.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_threshold(int v);
        wait_drained();
        gimbal_threshold <= 15'(v);
        gimbal_threshold_we <= 1'b1;
        @(negedge clk);
        gimbal_threshold_we <= 1'b0;
        thr_model = v;
    endtask

    function automatic int rand_elem();
        case ($urandom_range(0, 5))
            0: return 16384;
            1: return -16384;
            2: return 0;
            3: return $urandom_range(0, 65535) - 32768;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    task automatic test_directed();
        send_matrix(16384, 0, 0, 0, 16384, 0, 16384);
        send_matrix(-16384, 0, 0, 0, -16384, 0, -16384);
        send_matrix(0, 0, 0, 0, 0, 0, 0);
        send_matrix(16384, 0, 16384, 0, 16384, 0, 0);
        send_matrix(16384, 0, -16384, 100, -16384, 0, 0);
        send_matrix(0, 0, 16352, 5000, 9000, 0, 0);
        send_matrix(0, 0, 16353, 5000, 9000, 0, 0);
        send_matrix(0, 0, -16353, -5000, -9000, 0, 0);
        send_matrix(-100, 0, 0, 0, 0, 100, -100);
        send_matrix(-100, 100, 0, 0, 0, -100, -100);
        send_matrix(32767, -32768, 32767, -32768, 32767, -32768, 32767);
        send_matrix(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
        send_matrix(0, 0, 20000, 0, 0, 0, 0);
        send_matrix(0, 0, -20000, 0, 0, 0, 0);
    endtask

    task automatic test_thresholds();
        int levels[4] = '{0, 32767, 16384, 8000};
        foreach (levels[k])
        begin
            write_threshold(levels[k]);
            for (int n = 0; n < 40; n++)
                send_matrix(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                            rand_elem(), rand_elem(), rand_elem());
            send_matrix(1, 1, levels[k], 1, 1, 1, 1);
            send_matrix(1, 1, -levels[k] - 1, 1, 1, 1, 1);
        end
        write_threshold(16352);
    endtask

    task automatic test_random();
        for (int n = 0; n < 1500; n++)
        begin
            if (n == 1200)
                idle_off = 1'b1;
            send_matrix(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                        rand_elem(), rand_elem(), rand_elem());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        gimbal_threshold_we = 1'b0;
        gimbal_threshold = '0;
        {r00, r01, r02, r10, r11, r12, r22} = '0;
        errors = 0;
        idle_off = 1'b0;
        thr_model = 16352;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_thresholds();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_wait != 0)
            pop_wait = pop_wait - 1;
        else if (!idle_off && $urandom_range(0, 15) == 0)
        begin
            pop_wait = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        angles_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("unexpected item");
                errors++;
            end
            else
            begin
                e = expected_angles.pop_front();
                if (pitch_deg !== e.pitch)
                begin
                    $error("pitch_deg expected %0d actual %0d", e.pitch, pitch_deg);
                    errors++;
                end
                if (yaw_deg !== e.yaw)
                begin
                    $error("yaw_deg expected %0d actual %0d", e.yaw, yaw_deg);
                    errors++;
                end
                if (roll_deg !== e.roll)
                begin
                    $error("roll_deg expected %0d actual %0d", e.roll, roll_deg);
                    errors++;
                end
            end
        end
    end
endmodule
